@@ design/assert_macros.svh @@
// assert_macros.svh: assertion macros for the list engine modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define BAL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/bal_pkg.sv @@
// bal_pkg: shared types and codes of the bounded array list engine.
// No dependencies; imported by the controller, the register block and the top.
`timescale 1ns / 1ps

package bal_pkg;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_UPD_VAL   = 3'd2,
    KIND_UPD_POS   = 3'd3,
    KIND_DEL_VAL   = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_SRCH_VAL  = 3'd6,
    KIND_RD_POS    = 3'd7
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_MISS = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_SHIFT_UP,
    ST_FRONT
  } state_e;

  // Register map
  localparam int unsigned CFG_AW  = 3;
  localparam logic        CAP_IDX = 1'b0;

  // One result item
  typedef struct packed {
    status_e            status;
    logic signed [31:0] old_value;
    logic [3:0]         position;
    logic [4:0]         total;
  } bal_result_t;

endpackage

@@ design/bal_ram.sv @@
// bal_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
`timescale 1ns / 1ps

module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/bal_cfg.sv @@
// bal_cfg: APB-style register block holding the capacity limit.
// Depends on bal_pkg for the register map.
`timescale 1ns / 1ps

module bal_cfg import bal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [4:0]        limit_o
);

  logic [4:0] cap_q, cap_d;
  logic       wr_en;

  // Decode a completed write to the limit register
  assign wr_en = psel && penable && pwrite && (paddr[2] == CAP_IDX);

  always_comb begin
    cap_d = cap_q;
    if (wr_en) begin
      cap_d = pwdata[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else begin
      cap_q <= cap_d;
    end
  end

  // Read back; only bit 2 of the address is decoded, addresses with it set read zero
  assign prdata  = (paddr[2] == CAP_IDX) ? {27'b0, cap_q} : 32'b0;
  assign pready  = 1'b1;
  assign limit_o = cap_q;

endmodule

@@ design/bal_ctrl.sv @@
// bal_ctrl: sequencer that scans and shifts the list store one entry a cycle.
// Depends on bal_pkg and assert_macros.svh; drives the ports of one bal_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bal_ctrl import bal_pkg::*; #(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] match_operand_i,
  input  logic signed [31:0] new_value_i,
  input  logic [4:0]         limit_i,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [31:0]        ram_wdata_o,
  output logic               ram_re_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  logic [31:0]        ram_rdata_i,
  output logic               done_o,
  output bal_result_t        result_o
);

  localparam int CW = $clog2(DEPTH + 1);

  state_e         state_q, state_d;
  kind_e          kind_q, kind_d;
  logic [31:0]    operand_q, operand_d;
  logic [31:0]    newval_q, newval_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  ptr_q, ptr_d;
  logic [CW-1:0]  end_q, end_d;
  logic [AW-1:0]  tag_q, tag_d;
  logic           rv_q, rv_d;
  logic [31:0]    hold_old_q, hold_old_d;
  logic [AW-1:0]  hold_pos_q, hold_pos_d;
  logic           done_q, done_d;
  bal_result_t    res_q, res_d;

  kind_e          kind_in;
  logic           accept;
  logic           is_ins_in, is_pos_in, full, in_range;
  logic           is_upd_q, is_del_q, is_pos_q;
  logic           issue, rd_hit, scan_last, tail_hit;
  logic [CW-1:0]  up_ptr;

  assign kind_in   = kind_e'(kind_i);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign is_ins_in = kind_in inside {KIND_INS_FRONT, KIND_INS_END};
  assign is_pos_in = kind_in inside {KIND_UPD_POS, KIND_DEL_POS, KIND_RD_POS};
  assign full      = (32'(count_q) >= 32'(limit_i)) || (32'(count_q) >= 32'(DEPTH));
  assign in_range  = 32'(count_q) > $unsigned(match_operand_i);

  assign is_upd_q  = kind_q inside {KIND_UPD_VAL, KIND_UPD_POS};
  assign is_del_q  = kind_q inside {KIND_DEL_VAL, KIND_DEL_POS};
  assign is_pos_q  = kind_q inside {KIND_UPD_POS, KIND_DEL_POS, KIND_RD_POS};

  // Read tracking: data returned this cycle belongs to entry tag_q
  assign issue     = ptr_q < end_q;
  assign rd_hit    = rv_q && (is_pos_q || (ram_rdata_i == operand_q));
  assign scan_last = rv_q && ((CW'(tag_q) + CW'(1)) == end_q);
  assign tail_hit  = (CW'(tag_q) + CW'(1)) == count_q;
  assign up_ptr    = ptr_q - CW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_ins_in) begin
            if (!full && (kind_in == KIND_INS_FRONT) && (count_q != '0)) begin
              state_d = ST_SHIFT_UP;
            end
          end else if (is_pos_in) begin
            if (in_range) begin
              state_d = ST_SCAN;
            end
          end else if (count_q != '0) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_hit) begin
          state_d = (is_del_q && !tail_hit) ? ST_SHIFT_DN : ST_IDLE;
        end else if (scan_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT_DN: begin
        if (rv_q && tail_hit) begin
          state_d = ST_IDLE;
        end
      end
      ST_SHIFT_UP: begin
        if (rv_q && (tag_q == '0)) begin
          state_d = ST_FRONT;
        end
      end
      ST_FRONT: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory port and result
  always_comb begin
    kind_d      = kind_q;
    operand_d   = operand_q;
    newval_d    = newval_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    end_d       = end_q;
    tag_d       = tag_q;
    rv_d        = 1'b0;
    hold_old_d  = hold_old_q;
    hold_pos_d  = hold_pos_q;
    done_d      = 1'b0;
    res_d       = res_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = tag_q;
    ram_wdata_o = newval_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q[AW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d    = kind_in;
          operand_d = match_operand_i;
          newval_d  = new_value_i;
          if (is_ins_in) begin
            if (full) begin
              done_d = 1'b1;
              res_d  = '{STAT_FULL, 32'sd0, 4'd0, 5'd0};
            end else if (kind_in == KIND_INS_END) begin
              // append directly at the count
              ram_we_o    = 1'b1;
              ram_waddr_o = count_q[AW-1:0];
              ram_wdata_o = new_value_i;
              count_d     = count_q + CW'(1);
              done_d      = 1'b1;
              res_d       = '{STAT_DONE, 32'sd0, 4'(count_q), 5'd0};
            end else if (count_q == '0) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = '0;
              ram_wdata_o = new_value_i;
              count_d     = CW'(1);
              done_d      = 1'b1;
              res_d       = '{STAT_DONE, 32'sd0, 4'd0, 5'd0};
            end else begin
              ptr_d = count_q;
            end
          end else if (is_pos_in) begin
            if (in_range) begin
              ptr_d = match_operand_i[CW-1:0];
              end_d = match_operand_i[CW-1:0] + CW'(1);
            end else begin
              done_d = 1'b1;
              res_d  = '{STAT_MISS, 32'sd0, 4'd0, 5'd0};
            end
          end else if (count_q == '0) begin
            done_d = 1'b1;
            res_d  = '{STAT_MISS, 32'sd0, 4'd0, 5'd0};
          end else begin
            ptr_d = '0;
            end_d = count_q;
          end
        end
      end

      ST_SCAN: begin
        // stream reads forward, compare each returned entry
        ram_re_o = issue;
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
          rv_d  = 1'b1;
          tag_d = ptr_q[AW-1:0];
        end
        if (rd_hit) begin
          rv_d       = 1'b0;
          hold_old_d = ram_rdata_i;
          hold_pos_d = tag_q;
          if (is_upd_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = tag_q;
            ram_wdata_o = newval_q;
            done_d      = 1'b1;
            res_d       = '{STAT_DONE, ram_rdata_i, 4'(tag_q), 5'd0};
          end else if (is_del_q) begin
            if (tail_hit) begin
              count_d = count_q - CW'(1);
              done_d  = 1'b1;
              res_d   = '{STAT_DONE, ram_rdata_i, 4'(tag_q), 5'd0};
            end else begin
              ptr_d = CW'(tag_q) + CW'(1);
              end_d = count_q;
            end
          end else begin
            done_d = 1'b1;
            res_d  = '{STAT_DONE, ram_rdata_i, 4'(tag_q), 5'd0};
          end
        end else if (scan_last) begin
          rv_d   = 1'b0;
          done_d = 1'b1;
          res_d  = '{STAT_MISS, 32'sd0, 4'd0, 5'd0};
        end
      end

      ST_SHIFT_DN: begin
        // read entry k, write it back at k-1 next cycle
        ram_re_o = issue;
        if (issue) begin
          ptr_d = ptr_q + CW'(1);
          rv_d  = 1'b1;
          tag_d = ptr_q[AW-1:0];
        end
        if (rv_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = tag_q - AW'(1);
          ram_wdata_o = ram_rdata_i;
          if (tail_hit) begin
            count_d = count_q - CW'(1);
            done_d  = 1'b1;
            res_d   = '{STAT_DONE, hold_old_q, 4'(hold_pos_q), 5'd0};
          end
        end
      end

      ST_SHIFT_UP: begin
        // read entry k from the top down, write it back at k+1
        ram_re_o    = ptr_q != '0;
        ram_raddr_o = up_ptr[AW-1:0];
        if (ptr_q != '0) begin
          ptr_d = up_ptr;
          rv_d  = 1'b1;
          tag_d = up_ptr[AW-1:0];
        end
        if (rv_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = tag_q + AW'(1);
          ram_wdata_o = ram_rdata_i;
        end
      end

      ST_FRONT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = newval_q;
        count_d     = count_q + CW'(1);
        done_d      = 1'b1;
        res_d       = '{STAT_DONE, 32'sd0, 4'd0, 5'd0};
      end

      default: begin
      end
    endcase

    // Report the count left after the operation
    if (done_d) begin
      res_d.total = 5'(count_d);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    operand_q  <= operand_d;
    newval_q   <= newval_d;
    ptr_q      <= ptr_d;
    end_q      <= end_d;
    tag_q      <= tag_d;
    hold_old_q <= hold_old_d;
    hold_pos_q <= hold_pos_d;
    res_q      <= res_d;
  end

  assign busy_o   = state_q != ST_IDLE;
  assign done_o   = done_q;
  assign result_o = res_q;

  `BAL_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "entry count exceeds store depth")
  `BAL_ASSERT(a_no_rw_collide, !(ram_we_o && ram_re_o && (ram_waddr_o == ram_raddr_o)),
    "read and write of the same entry in one cycle")
  `BAL_ASSERT(a_count_on_result, (count_d != count_q) |-> done_d,
    "entry count changed without a result")
  `BAL_ASSERT_NEXT(a_result_on_exit, (state_q != ST_IDLE) && (state_d == ST_IDLE), done_q,
    "sequence ended without a result")

endmodule

@@ design/bounded_array_list_engine.sv @@
// bounded_array_list_engine: top level of the bounded array list engine.
// Depends on bal_pkg, bal_cfg, bal_ctrl and bal_ram.
//
// Usage: write capacity_limit over the APB-style port (byte address 0) while
// idle. Present an item on kind_i, match_operand_i and new_value_i with start
// high; it is taken at an edge where busy is low. Exactly one result comes
// back on status_o, old_value_o, match_position_o and entry_total_o, marked by
// done_o for one cycle; the receiver cannot stall it. A new item may be taken
// in the cycle the previous result is on the ports.
// Insert at the end, failed inserts and out-of-range positions are settled in
// the accepting cycle, with done_o in the cycle after; an empty list settles
// searches and front inserts the same way. Reads and updates by position fetch
// that entry; by value they scan from the front to the first equal entry, and
// a value not found scans the whole list. A delete locates the same way, then
// shifts the later entries down one place, with no shift at the tail. Insert
// front shifts every entry up one place from the top, then writes position 0.
// The entry store is one RAM with one write and one registered read port;
// scans and shifts move through it one entry per cycle.
// Reset clears the count and the limit; the store is not cleared.
`timescale 1ns / 1ps

module bounded_array_list_engine import bal_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] match_operand_i,
  input  logic signed [31:0] new_value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] old_value_o,
  output logic [3:0]         match_position_o,
  output logic [4:0]         entry_total_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [4:0]    limit;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;
  bal_result_t   result;

  // Configuration registers
  bal_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // Sequencer
  bal_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .kind_i          (kind_i),
    .match_operand_i (match_operand_i),
    .new_value_i     (new_value_i),
    .limit_i         (limit),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata),
    .done_o          (done_o),
    .result_o        (result)
  );

  // Entry store
  bal_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Unpack the result item
  assign status_o         = result.status;
  assign old_value_o      = result.old_value;
  assign match_position_o = result.position;
  assign entry_total_o    = result.total;

endmodule

@@ sim/bal_checker.sv @@
`timescale 1ns / 1ps
// bal_checker: watches the command, result and register ports of the list engine,
// keeps its own copy of the list and compares every result against it in order.
// Depends on bal_pkg; instantiated by the testbench beside the engine.

module bal_checker import bal_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  input  logic              start,
  input  logic              busy,
  input  logic [2:0]        kind_i,
  input  logic [31:0]       match_operand_i,
  input  logic [31:0]       new_value_i,
  input  logic              done_o,
  input  logic [1:0]        status_o,
  input  logic [31:0]       old_value_o,
  input  logic [3:0]        match_position_o,
  input  logic [4:0]        entry_total_o,
  output int                fail_count,
  output int                outstanding
);

  typedef struct packed {
    kind_e       kind;
    bal_result_t res;
  } list_result_t;

  logic [31:0]  list_words [DEPTH];
  int           held;
  logic [4:0]   cap_limit;
  list_result_t expected_q [$];

  // Apply one request to the shadow list and build its result
  task automatic apply_request(input kind_e k, input logic [31:0] opnd,
                               input logic [31:0] nv, output bal_result_t r);
    int lim;
    int pos;
    lim = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
    r = '0;
    r.status = STAT_DONE;
    if (k == KIND_INS_FRONT || k == KIND_INS_END) begin
      if (held >= lim) begin
        r.status = STAT_FULL;
      end else if (k == KIND_INS_FRONT) begin
        for (int i = held; i > 0; i--) list_words[i] = list_words[i-1];
        list_words[0] = nv;
        held++;
      end else begin
        r.position = 4'(held);
        list_words[held] = nv;
        held++;
      end
    end else begin
      // locate by position or by first equal entry
      if (k == KIND_UPD_POS || k == KIND_DEL_POS || k == KIND_RD_POS) begin
        pos = (opnd < 32'(held)) ? int'(opnd) : held;
      end else begin
        pos = held;
        for (int i = held - 1; i >= 0; i--) if (list_words[i] == opnd) pos = i;
      end
      if (pos >= held) begin
        r.status = STAT_MISS;
      end else begin
        r.old_value = list_words[pos];
        r.position = 4'(pos);
        if (k == KIND_UPD_VAL || k == KIND_UPD_POS) begin
          list_words[pos] = nv;
        end else if (k == KIND_DEL_VAL || k == KIND_DEL_POS) begin
          for (int i = pos; i + 1 < held; i++) list_words[i] = list_words[i+1];
          held--;
        end
      end
    end
    r.total = 5'(held);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    bal_result_t  seen;
    if (!rst_ni) begin
      held = 0;
      cap_limit = '0;
      expected_q.delete();
      fail_count = 0;
      outstanding = 0;
    end else begin
      // compare a finished item with the oldest prediction
      if (done_o) begin
        seen.status    = status_e'(status_o);
        seen.old_value = old_value_o;
        seen.position  = match_position_o;
        seen.total     = entry_total_o;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no item pending: status %0d old %0d pos %0d total %0d",
                     $realtime, status_o, $signed(old_value_o), match_position_o,
                     entry_total_o);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want.res) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch kind %0d: expected status %0d old %0d pos %0d total %0d, got status %0d old %0d pos %0d total %0d",
                       $realtime, want.kind, want.res.status, $signed(want.res.old_value),
                       want.res.position, want.res.total, status_o,
                       $signed(old_value_o), match_position_o, entry_total_o);
          end
        end
      end
      // predict an accepted item
      if (start && !busy) begin
        want.kind = kind_e'(kind_i);
        apply_request(want.kind, match_operand_i, new_value_i, want.res);
        expected_q.push_back(want);
      end
      // track writes of the limit, check reads of it
      if (psel && penable && pready && paddr[CFG_AW-1:2] == CAP_IDX) begin
        if (pwrite) begin
          cap_limit = pwdata[4:0];
        end else if (prdata !== {27'b0, cap_limit}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: limit readback expected %0d, got %0d", $realtime,
                     cap_limit, prdata);
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: drives items and limit settings into bounded_array_list_engine and
// gives the verdict; prediction and comparison live in bal_checker.
// Depends on bal_pkg, bal_checker and the engine RTL.

module testbench import bal_pkg::*;;

  localparam int DEPTH = 16;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 181;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int END_WAIT = 4000;
  localparam logic [CFG_AW-1:0] CAP_ADDR = {CAP_IDX, 2'b00};
  localparam logic [CFG_AW-1:0] SPARE_ADDR = {~CAP_IDX, 2'b00};

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        kind_i = '0;
  logic [31:0]       match_operand_i = '0;
  logic [31:0]       new_value_i = '0;
  logic              done_o;
  logic [1:0]        status_o;
  logic [31:0]       old_value_o;
  logic [3:0]        match_position_o;
  logic [4:0]        entry_total_o;
  int                fail_count;
  int                outstanding;

  int                idle_pct = 0;
  int                quiet_left = 0;
  logic [31:0]       value_pool [8];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  bounded_array_list_engine #(.DEPTH(DEPTH)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .match_operand_i (match_operand_i),
    .new_value_i     (new_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .old_value_o     (old_value_o),
    .match_position_o(match_position_o),
    .entry_total_o   (entry_total_o)
  );

  bal_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .match_operand_i (match_operand_i),
    .new_value_i     (new_value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .old_value_o     (old_value_o),
    .match_position_o(match_position_o),
    .entry_total_o   (entry_total_o),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // Present one item, hold it until taken, then maybe idle
  task automatic send_item(input kind_e k, input logic [31:0] opnd, input logic [31:0] nv);
    start <= 1'b1;
    kind_i <= k;
    match_operand_i <= opnd;
    new_value_i <= nv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(99) < 4) begin
      quiet_left = $urandom_range(10, 30);
    end else if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic read_reg(input logic [CFG_AW-1:0] addr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain the engine, then set a new limit with junk in the upper bits
  task automatic set_limit(input logic [4:0] cap);
    logic [31:0] raw;
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
    raw = $urandom;
    write_reg(SPARE_ADDR, raw);
    raw = $urandom;
    raw[4:0] = cap;
    write_reg(CAP_ADDR, raw);
    read_reg(CAP_ADDR);
  endtask

  function automatic logic [4:0] phase_limit(input int p);
    case (p)
      0:       return 5'd16;
      1:       return 5'd1;
      2:       return 5'd31;
      3:       return 5'd3;
      4:       return 5'd0;
      5:       return 5'd5;
      6:       return 5'd16;
      7:       return 5'd12;
      default: return 5'd31;
    endcase
  endfunction

  // Random request: values and match values mostly from a small value pool so matches occur
  task automatic send_random_item();
    kind_e       k;
    logic [31:0] opnd;
    logic [31:0] nv;
    int          r;
    r = $urandom_range(99);
    if (r < 20) k = KIND_INS_END;
    else if (r < 35) k = KIND_INS_FRONT;
    else k = kind_e'($urandom_range(2, 7));
    nv = ($urandom_range(3) == 0) ? $urandom : value_pool[$urandom_range(7)];
    if (k == KIND_UPD_POS || k == KIND_DEL_POS || k == KIND_RD_POS)
      opnd = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, DEPTH + 1));
    else if (k == KIND_UPD_VAL || k == KIND_DEL_VAL || k == KIND_SRCH_VAL)
      opnd = ($urandom_range(4) == 0) ? $urandom : value_pool[$urandom_range(7)];
    else
      opnd = $urandom;
    send_item(k, opnd, nv);
    if ($urandom_range(15) == 0) value_pool[$urandom_range(7)] = $urandom;
  endtask

  initial begin
    int n;
    int w;
    value_pool[0] = 32'h7fff_ffff;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    read_reg(CAP_ADDR);

    // every kind on an empty list with the reset limit of zero
    for (int k = 0; k < 8; k++) send_item(kind_e'(k), 32'h0, 32'h0);

    // limit above the store depth; extremes, misses and first-match cases
    set_limit(5'd31);
    send_item(KIND_INS_END, 32'h0, 32'h7fff_ffff);
    send_item(KIND_INS_FRONT, 32'h0, 32'h8000_0000);
    send_item(KIND_INS_END, 32'h0, 32'h0000_0000);
    send_item(KIND_INS_END, 32'h0, 32'hffff_ffff);
    send_item(KIND_INS_END, 32'h0, 32'hffff_ffff);
    send_item(KIND_SRCH_VAL, 32'h8000_0000, 32'h0);
    send_item(KIND_RD_POS, 32'd4, 32'h0);
    send_item(KIND_RD_POS, 32'hffff_ffff, 32'h0);
    send_item(KIND_RD_POS, 32'd5, 32'h0);
    send_item(KIND_UPD_VAL, 32'hffff_ffff, 32'd5);
    send_item(KIND_UPD_POS, 32'd0, 32'h5555_5555);
    send_item(KIND_UPD_POS, 32'h8000_0000, 32'haaaa_aaaa);
    send_item(KIND_DEL_VAL, 32'h7fff_ffff, 32'h0);
    send_item(KIND_DEL_POS, 32'd0, 32'h0);
    send_item(KIND_DEL_POS, 32'h8000_0000, 32'h0);
    send_item(KIND_SRCH_VAL, 32'haaaa_aaaa, 32'h0);
    send_item(KIND_DEL_VAL, 32'h1234_5678, 32'h0);

    // random phases; each phase with limit 31 starts by filling the list
    for (int p = 0; p < PHASES; p++) begin
      set_limit(phase_limit(p));
      idle_pct = (p < 3) ? 32 : (p < 6) ? 45 : 0;
      n = 0;
      if (phase_limit(p) == 5'd31) begin
        for (; n < DEPTH; n++) send_item(KIND_INS_END, $urandom, value_pool[$urandom_range(7)]);
      end
      for (; n < PHASE_ITEMS; n++) send_random_item();
    end

    // wait out the remaining results, then settle
    start <= 1'b0;
    for (w = 0; w < END_WAIT && outstanding != 0; w++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/bal_pkg.sv
design/bal_ram.sv
design/bal_cfg.sv
design/bal_ctrl.sv
design/bounded_array_list_engine.sv
sim/bal_checker.sv
sim/testbench.sv
